FILE: rtl/string_to_unsigned_parser_top_macros.svh
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_top_macros
// Assertion macros used by stup_back; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STRING_TO_UNSIGNED_PARSER_TOP_MACROS_SVH
`define STRING_TO_UNSIGNED_PARSER_TOP_MACROS_SVH

`ifndef SYNTH
`define STUP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("stup: invariant violated");
`define STUP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stup: sequence violated");
`else
`define STUP_ASSERT_ALWAYS(lbl, expr)
`define STUP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/stup_pkg.sv
// ----------------------------------------------------------------------------
// stup_pkg
// Widths, character codes, queue sizing and shared types of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stup_pkg;

    localparam int MAX_CHARS = 4096;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int VALUE_W   = 64;
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 8;
    localparam int DVAL_W    = 6;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic REG_RADIX_MODE = 1'b0;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] BASE_AUTO   = RADIX_W'(0);
    localparam logic [RADIX_W-1:0] BASE_OCT    = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] BASE_DEC    = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] BASE_HEX    = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic              start;
        logic              blank;
        logic              zero;
        logic              xchar;
        logic              alnum;
        logic [DVAL_W-1:0] dval;
    } item_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_BLANK  = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

FILE: rtl/string_to_unsigned_parser_top.sv
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_top
// Streaming unsigned integer parser: one character per word, one result word
// per parsed string.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   char_in, start_of_string
//   out      output     out_valid/out_stall parsed_value, end_offset
//   cfg      APB        psel/penable        radix_mode at byte address 0
//
// One character per cycle sustained while out_stall is low; the loop that sets
// it is the 64x6 multiply-add on the accumulator in the back end.
// out_valid is registered; it rises after the back end takes the ending character.
// A two-word queue sits between classifier and back end; out_stall backs up
// into it, then into in_stall.
// Reset clears control state only; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_unsigned_parser_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [stup_pkg::CHAR_W-1:0]  char_in,
    input  wire logic                         start_of_string,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    output logic [stup_pkg::VALUE_W-1:0]      parsed_value,
    output logic [stup_pkg::CNT_W-1:0]        end_offset,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stup_pkg::PADDR_W-1:0] paddr,
    input  wire logic [stup_pkg::PDATA_W-1:0] pwdata,
    output logic [stup_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import stup_pkg::*;

    logic [RADIX_W-1:0] radix_mode_reg;
    logic               head_valid;
    item_t              head;
    logic               take;
    logic               reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_RADIX_MODE);
    assign prdata  = reg_hit ? PDATA_W'(radix_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_mode_reg <= RADIX_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            radix_mode_reg <= pwdata[RADIX_W-1:0];
        end
    end

    stup_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_in         (char_in),
        .start_of_string (start_of_string),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .head_valid      (head_valid),
        .head            (head),
        .take            (take)
    );

    stup_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .radix_mode   (radix_mode_reg),
        .head_valid   (head_valid),
        .head         (head),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parsed_value (parsed_value),
        .end_offset   (end_offset)
    );

endmodule

`default_nettype wire

FILE: rtl/stup_front.sv
// ----------------------------------------------------------------------------
// stup_front
// Classifies each accepted character and queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module stup_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [stup_pkg::CHAR_W-1:0] char_in,
    input  wire logic                        start_of_string,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    output logic                             head_valid,
    output stup_pkg::item_t                  head,
    input  wire logic                        take
);
    import stup_pkg::*;

    item_t              cls;
    item_t              q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] q_cnt_reg;
    logic [Q_CNT_W-1:0] q_cnt_next;
    logic               enq;

    always_comb
    begin
        cls.start = start_of_string;
        cls.blank = (char_in == CH_SPACE) || (char_in == CH_TAB);
        cls.zero  = (char_in == CH_ZERO);
        cls.xchar = (char_in == CH_LC_X) || (char_in == CH_UC_X);
        cls.alnum = 1'b1;
        cls.dval  = '0;
        if (char_in >= CH_ZERO && char_in <= CH_NINE)
        begin
            cls.dval = DVAL_W'(char_in - CH_ZERO);
        end
        else if (char_in >= CH_LC_A && char_in <= CH_LC_Z)
        begin
            cls.dval = DVAL_W'(char_in - CH_LC_A) + DVAL_W'(10);
        end
        else if (char_in >= CH_UC_A && char_in <= CH_UC_Z)
        begin
            cls.dval = DVAL_W'(char_in - CH_UC_A) + DVAL_W'(10);
        end
        else
        begin
            cls.alnum = 1'b0;
        end
    end

    assign in_stall   = (q_cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign enq        = in_valid && !in_stall;
    assign head_valid = (q_cnt_reg != '0);
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (enq && !take)
        begin
            q_cnt_next = q_cnt_reg + 1'b1;
        end
        else if (!enq && take)
        begin
            q_cnt_next = q_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stup_back.sv
// ----------------------------------------------------------------------------
// stup_back
// Parse state machine, multiply-add accumulator and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "string_to_unsigned_parser_top_macros.svh"

module stup_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [stup_pkg::RADIX_W-1:0] radix_mode,
    input  wire logic                         head_valid,
    input  wire stup_pkg::item_t              head,
    output logic                              take,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [stup_pkg::VALUE_W-1:0]      parsed_value,
    output logic [stup_pkg::CNT_W-1:0]        end_offset
);
    import stup_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    phase_t             cur_phase;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [VALUE_W-1:0] acc_src;
    logic [VALUE_W-1:0] mac;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_src;
    logic [CNT_W-1:0]   cnt_inc;
    logic [RADIX_W-1:0] base_reg;
    logic [RADIX_W-1:0] base_next;
    logic [RADIX_W-1:0] use_base;
    logic               try_digit;
    logic               digit_ok;
    logic               emit;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] parsed_value_reg;
    logic [CNT_W-1:0]   end_offset_reg;

    assign take      = head_valid && (!out_valid_reg || !out_stall);
    assign cur_phase = head.start ? PH_BLANK : phase_reg;
    assign acc_src   = head.start ? '0 : acc_reg;
    assign cnt_src   = head.start ? '0 : cnt_reg;
    assign cnt_inc   = (cnt_src < CNT_W'(MAX_CHARS)) ? cnt_src + 1'b1 : cnt_src;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        base_next  = base_reg;
        use_base   = base_reg;
        try_digit  = 1'b0;
        emit       = 1'b0;
        if (take)
        begin
            phase_next = cur_phase;
            acc_next   = acc_src;
            cnt_next   = cnt_src;
            unique case (cur_phase)
                PH_BLANK:
                begin
                    if (head.blank)
                    begin
                        cnt_next = cnt_inc;
                    end
                    else if (radix_mode == BASE_AUTO)
                    begin
                        if (head.zero)
                        begin
                            base_next  = BASE_OCT;
                            cnt_next   = cnt_inc;
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            base_next = BASE_DEC;
                            use_base  = BASE_DEC;
                            try_digit = 1'b1;
                        end
                    end
                    else
                    begin
                        base_next = radix_mode;
                        use_base  = radix_mode;
                        if (radix_mode == BASE_HEX && head.zero)
                        begin
                            cnt_next   = cnt_inc;
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            try_digit = 1'b1;
                        end
                    end
                end
                PH_ZERO:
                begin
                    if (head.xchar)
                    begin
                        base_next  = BASE_HEX;
                        cnt_next   = cnt_inc;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        try_digit = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    try_digit = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (try_digit)
            begin
                if (digit_ok)
                begin
                    acc_next   = mac;
                    cnt_next   = cnt_inc;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
            end
        end
    end

    assign digit_ok = head.alnum && (head.dval < use_base);
    assign mac      = acc_src * VALUE_W'(use_base) + VALUE_W'(head.dval);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            base_reg      <= RADIX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            parsed_value_reg <= acc_src;
            end_offset_reg   <= cnt_src;
        end
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = parsed_value_reg;
    assign end_offset   = end_offset_reg;

    `STUP_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(MAX_CHARS))
    `STUP_ASSERT_ALWAYS(a_no_take_blocked, !(take && out_valid_reg && out_stall))
    `STUP_ASSERT_NEXT(a_emit_loads, emit, out_valid_reg && phase_reg == PH_DONE)
    `STUP_ASSERT_ALWAYS(a_idle_silent,
        !(emit && !head.start && (phase_reg == PH_IDLE || phase_reg == PH_DONE)))

endmodule

`default_nettype wire
